// ----- hdl/rhc_pkg.sv -----
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared types and constants for the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int NUM_BITS     = CHANNEL_BITS + 3;
    localparam int DIV_BITS     = 2 * CHANNEL_BITS + 3;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
        logic [CHANNEL_BITS-1:0] alpha;
    } t_rgba;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] hue;
        logic [CHANNEL_BITS-1:0] saturation;
        logic [CHANNEL_BITS-1:0] brightness;
        logic [CHANNEL_BITS-1:0] opacity;
    } t_hsva;

    typedef struct packed {
        logic                    gray;
        logic [CHANNEL_BITS-1:0] value;
        logic [CHANNEL_BITS-1:0] alpha;
        logic [CHANNEL_BITS-1:0] chroma;
        logic [NUM_BITS-1:0]     num;
    } t_front;

    typedef struct packed {
        logic                    gray;
        logic [CHANNEL_BITS-1:0] value;
        logic [CHANNEL_BITS-1:0] alpha;
        logic [DIV_BITS-1:0]     hue_rem;
        logic [DIV_BITS-1:0]     hue_div;
        logic [CHANNEL_BITS-1:0] hue_quo;
        logic [DIV_BITS-1:0]     sat_rem;
        logic [DIV_BITS-1:0]     sat_div;
        logic [CHANNEL_BITS-1:0] sat_quo;
    } t_div;

endpackage

// ----- hdl/rhc_front.sv -----
// ----------------------------------------------------------------------------
// rhc_front
// Two pipeline stages: channel extremes and hue numerator, then the
// scaled dividends and aligned divisors for the division cells.
// ----------------------------------------------------------------------------
module rhc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  rhc_pkg::t_rgba i_pixel,
    output logic          o_valid,
    output rhc_pkg::t_div o_data
);

    localparam int W  = rhc_pkg::CHANNEL_BITS;
    localparam int NB = rhc_pkg::NUM_BITS;
    localparam int DB = rhc_pkg::DIV_BITS;

    logic           r_a_valid;
    rhc_pkg::t_front r_a;
    rhc_pkg::t_front n_a;
    logic           r_b_valid;
    rhc_pkg::t_div  r_b;
    rhc_pkg::t_div  n_b;

    logic [W-1:0]  mx;
    logic [W-1:0]  mn;
    logic [NB-1:0] r_e, g_e, b_e, d_e;
    logic [DB-1:0] num_x, d_x, v_x, d6_x;

    always_comb begin
        mx = i_pixel.red;
        mn = i_pixel.red;
        if (i_pixel.green > mx) mx = i_pixel.green;
        if (i_pixel.blue > mx) mx = i_pixel.blue;
        if (i_pixel.green < mn) mn = i_pixel.green;
        if (i_pixel.blue < mn) mn = i_pixel.blue;
        r_e = NB'(i_pixel.red);
        g_e = NB'(i_pixel.green);
        b_e = NB'(i_pixel.blue);
        d_e = NB'(mx - mn);
        n_a.gray   = (mx == mn);
        n_a.value  = mx;
        n_a.alpha  = i_pixel.alpha;
        n_a.chroma = mx - mn;
        if (mx == i_pixel.red) begin
            if (i_pixel.green < i_pixel.blue) begin
                n_a.num = (d_e << 2) + (d_e << 1) - (b_e - g_e);
            end else begin
                n_a.num = g_e - b_e;
            end
        end else if (mx == i_pixel.green) begin
            n_a.num = (d_e << 1) + b_e - r_e;
        end else begin
            n_a.num = (d_e << 2) + r_e - g_e;
        end
    end

    always_comb begin
        num_x = DB'(r_a.num);
        d_x   = DB'(r_a.chroma);
        v_x   = DB'(r_a.value);
        d6_x  = (d_x << 2) + (d_x << 1);
        n_b.gray    = r_a.gray;
        n_b.value   = r_a.value;
        n_b.alpha   = r_a.alpha;
        n_b.hue_rem = (num_x << W) - num_x;
        n_b.hue_div = d6_x << (W - 1);
        n_b.hue_quo = '0;
        n_b.sat_rem = (d_x << W) - d_x;
        n_b.sat_div = v_x << (W - 1);
        n_b.sat_quo = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= n_a;
            r_b <= n_b;
        end
    end

    assign o_valid = r_b_valid;
    assign o_data  = r_b;

endmodule

// ----- hdl/rhc_div_cell.sv -----
// ----------------------------------------------------------------------------
// rhc_div_cell
// One quotient bit of both the hue and the saturation division.
// ----------------------------------------------------------------------------
module rhc_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  rhc_pkg::t_div i_data,
    output logic          o_valid,
    output rhc_pkg::t_div o_data
);

    localparam int W = rhc_pkg::CHANNEL_BITS;

    logic          r_valid;
    rhc_pkg::t_div r_data;
    rhc_pkg::t_div n_data;
    logic          hue_ge;
    logic          sat_ge;

    always_comb begin
        hue_ge = (i_data.hue_rem >= i_data.hue_div);
        sat_ge = (i_data.sat_rem >= i_data.sat_div);
        n_data.gray    = i_data.gray;
        n_data.value   = i_data.value;
        n_data.alpha   = i_data.alpha;
        n_data.hue_rem = hue_ge ? (i_data.hue_rem - i_data.hue_div) : i_data.hue_rem;
        n_data.hue_div = i_data.hue_div >> 1;
        n_data.hue_quo = {i_data.hue_quo[W-2:0], hue_ge};
        n_data.sat_rem = sat_ge ? (i_data.sat_rem - i_data.sat_div) : i_data.sat_rem;
        n_data.sat_div = i_data.sat_div >> 1;
        n_data.sat_quo = {i_data.sat_quo[W-2:0], sat_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- hdl/rgb_to_hsv_converter.sv -----
// Two front stages and one division cell per quotient bit. Throughput is one
// pixel per cycle while the result side does not stall.
// The pipeline advances whenever its output register is empty or taken.
// Reset clears only the valid bits of the stages; no payload is cleared.
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Converts RGBA pixels to HSVA through a chain of restoring division cells.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  rhc_pkg::t_rgba i_pixel,
    output logic           o_valid,
    input  logic           i_stall,
    output rhc_pkg::t_hsva o_result
);

    localparam int W = rhc_pkg::CHANNEL_BITS;

    logic          en;
    logic          chain_valid [W+1];
    rhc_pkg::t_div chain_data  [W+1];
    rhc_pkg::t_div last;

    assign en      = !(chain_valid[W] && i_stall);
    assign o_stall = !en;

    rhc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_pixel (i_pixel),
        .o_valid (chain_valid[0]),
        .o_data  (chain_data[0])
    );

    for (genvar k = 0; k < W; k++) begin : g_cell
        rhc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (chain_valid[k]),
            .i_data  (chain_data[k]),
            .o_valid (chain_valid[k+1]),
            .o_data  (chain_data[k+1])
        );
    end

    assign last    = chain_data[W];
    assign o_valid = chain_valid[W];

    always_comb begin
        o_result.hue        = last.gray ? '0 : last.hue_quo;
        o_result.saturation = last.gray ? '0 : last.sat_quo;
        o_result.brightness = last.value;
        o_result.opacity    = last.alpha;
    end

endmodule

// ----- test/rgb_to_hsv_converter_tb.sv -----
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_tb
// Streams directed and random RGBA pixels through the converter with random
// gaps on the request side and random stalls on the result side. A scoreboard
// predicts each HSVA result with exact integer arithmetic and compares every
// field in order.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB           = rhc_pkg::CHANNEL_BITS;
    localparam int FULL_SCALE   = (1 << CB) - 1;
    localparam int NUM_RANDOM   = 1525;
    localparam int NUM_PHASES   = 8;
    localparam int DRAIN_CYCLES = 30;

    class hsv_scoreboard;
        rhc_pkg::t_hsva expected_q[$];
        int             errors = 0;

        function rhc_pkg::t_hsva hsv_of(rhc_pkg::t_rgba px);
            rhc_pkg::t_hsva res;
            int             r, g, b, mx, mn, d, num, hue, sat;
            r   = int'(px.red);
            g   = int'(px.green);
            b   = int'(px.blue);
            mx  = r;
            mn  = r;
            hue = 0;
            sat = 0;
            if (g > mx) mx = g;
            if (b > mx) mx = b;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            d = mx - mn;
            if (d != 0) begin
                if (mx == r) begin
                    num = (g < b) ? 6 * d - (b - g) : g - b;
                end else if (mx == g) begin
                    num = 2 * d + b - r;
                end else begin
                    num = 4 * d + r - g;
                end
                hue = (FULL_SCALE * num) / (6 * d);
                sat = (FULL_SCALE * d) / mx;
            end
            res.hue        = hue[CB-1:0];
            res.saturation = sat[CB-1:0];
            res.brightness = mx[CB-1:0];
            res.opacity    = px.alpha;
            return res;
        endfunction

        function void note_pixel(rhc_pkg::t_rgba px);
            expected_q.push_back(hsv_of(px));
        endfunction

        function void check_result(rhc_pkg::t_hsva got);
            rhc_pkg::t_hsva want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: h=%0d s=%0d v=%0d a=%0d",
                             got.hue, got.saturation, got.brightness, got.opacity);
                return;
            end
            want = expected_q.pop_front();
            if (got.hue !== want.hue || got.saturation !== want.saturation ||
                got.brightness !== want.brightness || got.opacity !== want.opacity) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: expected h=%0d s=%0d v=%0d a=%0d, ",
                              "got h=%0d s=%0d v=%0d a=%0d"},
                             want.hue, want.saturation, want.brightness, want.opacity,
                             got.hue, got.saturation, got.brightness, got.opacity);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_valid = 1'b0;
    logic           o_stall;
    rhc_pkg::t_rgba i_pixel = '0;
    logic           o_valid;
    logic           i_stall = 1'b0;
    rhc_pkg::t_hsva o_result;

    hsv_scoreboard sb = new;

    bit tx_calm = 1'b1;
    bit rx_calm = 1'b0;
    int stall_left = 0;
    int open_left = 0;

    rgb_to_hsv_converter DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_pixel  (i_pixel),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic rhc_pkg::t_rgba random_pixel();
        rhc_pkg::t_rgba px;
        int             kind, base, shared;
        px   = $urandom;
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
            base     = $urandom_range(3, FULL_SCALE - 3);
            px.red   = CB'(base + $urandom_range(0, 6) - 3);
            px.green = CB'(base + $urandom_range(0, 6) - 3);
            px.blue  = CB'(base + $urandom_range(0, 6) - 3);
        end else if (kind < 30) begin
            shared   = $urandom_range(0, FULL_SCALE);
            kind     = $urandom_range(0, 2);
            px.red   = CB'((kind == 0) ? 0 : (kind == 1) ? FULL_SCALE : shared);
            kind     = $urandom_range(0, 2);
            px.green = CB'((kind == 0) ? 0 : (kind == 1) ? FULL_SCALE : shared);
            kind     = $urandom_range(0, 2);
            px.blue  = CB'((kind == 0) ? 0 : (kind == 1) ? FULL_SCALE : shared);
        end
        return px;
    endfunction

    always @(negedge i_clk) begin
        if (rx_calm) begin
            stall_left = 0;
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (open_left > 0) begin
            open_left--;
            i_stall <= 1'b0;
        end else begin
            stall_left = pick_gap();
            open_left  = $urandom_range(0, 8);
            i_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_result);
    end

    task automatic drive_pixel(input rhc_pkg::t_rgba px);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (o_stall);
        sb.note_pixel(px);
    endtask

    task automatic drive_rgba(input int r, input int g, input int b, input int a);
        rhc_pkg::t_rgba px;
        px.red   = CB'(r);
        px.green = CB'(g);
        px.blue  = CB'(b);
        px.alpha = CB'(a);
        drive_pixel(px);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        drive_rgba(0, 0, 0, 0);
        drive_rgba(255, 255, 255, 255);
        drive_rgba(128, 128, 128, 8'hAA);
        drive_rgba(255, 0, 0, 8'h55);
        drive_rgba(0, 255, 0, 1);
        drive_rgba(0, 0, 255, 254);
        drive_rgba(255, 255, 0, 17);
        drive_rgba(0, 255, 255, 34);
        drive_rgba(255, 0, 255, 68);
        drive_rgba(255, 0, 1, 136);
        drive_rgba(255, 1, 0, 200);
        drive_rgba(200, 200, 50, 3);
        drive_rgba(10, 200, 200, 5);
        drive_rgba(200, 10, 200, 9);
        drive_rgba(1, 0, 0, 12);
        drive_rgba(0, 1, 0, 24);
        drive_rgba(0, 0, 1, 48);
        drive_rgba(255, 254, 254, 96);
        drive_rgba(254, 255, 255, 192);
        drive_rgba(1, 1, 0, 127);
        drive_rgba(8'hAA, 8'h55, 8'hAA, 8'h55);
        drive_rgba(8'h55, 8'hAA, 8'h55, 8'hAA);
        drive_rgba(1, 255, 128, 128);
        drive_rgba(128, 1, 255, 0);
        drive_rgba(1, 1, 1, 255);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase == 0) begin
                tx_calm = 1'b1;
                rx_calm = 1'b1;
            end else if (phase == 1) begin
                tx_calm = 1'b0;
                rx_calm = 1'b0;
            end else begin
                tx_calm = ($urandom_range(0, 3) == 0);
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            if (phase == NUM_PHASES / 2) wait_drained();
            for (int n = 0; n < NUM_RANDOM / NUM_PHASES + 1; n++)
                drive_pixel(random_pixel());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[rgb_to_hsv_converter] OK");
        end else begin
            $display("[rgb_to_hsv_converter] ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("[rgb_to_hsv_converter] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/rhc_pkg.sv
hdl/rhc_front.sv
hdl/rhc_div_cell.sv
hdl/rgb_to_hsv_converter.sv
test/rgb_to_hsv_converter_tb.sv
